/* src/slbc_pkg.sv */
// Package for the status LED blink code generator.
// Holds the item type, timing, phase and width constants; no dependencies.
package slbc_pkg;

  // One input item as it moves from the input register to the pattern logic
  typedef struct packed {
    logic       cal_request;
    logic [7:0] phase;
    logic [6:0] error_code;
    logic       tick;
  } item_t;

  // Error series timing, in ticks
  localparam logic [3:0] FLASH_ON_TICKS  = 4'd2;
  localparam logic [3:0] FLASH_OFF_TICKS = 4'd4;
  localparam logic [3:0] SERIES_PAUSE    = 4'd12;

  // Phase-driven blink timing, in ticks
  localparam logic [3:0] FAST_PERIOD = 4'd4;
  localparam logic [3:0] FAST_ON     = 4'd2;
  localparam logic [3:0] SLOW_PERIOD = 4'd12;
  localparam logic [3:0] SLOW_ON     = 4'd6;

  // Phase codes
  localparam logic [7:0] RUN_PHASE       = 8'd8;
  localparam logic [7:0] FAST_PHASE_LOW  = 8'd6;
  localparam logic [7:0] FAST_PHASE_HIGH = 8'd7;

  // tdata widths on the stream ports
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 8;

endpackage

/* src/slbc_pattern.sv */
// Pattern state and next-state logic of the status LED blink code generator.
// Depends on slbc_pkg for the item type and timing constants.
module slbc_pattern (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  slbc_pkg::item_t item,
  output logic           led_next
);
  import slbc_pkg::*;

  logic       led_level;
  logic [6:0] last_error;
  logic [6:0] flashes_done;
  logic [3:0] step_timer;
  logic [7:0] last_phase;

  logic       led_level_next;
  logic [6:0] last_error_next;
  logic [6:0] flashes_done_next;
  logic [3:0] step_timer_next;
  logic [7:0] last_phase_next;

  logic       series_step;
  logic       fast_phase;
  logic [3:0] t;

  // Compute the state after one item
  always_comb begin
    led_level_next    = led_level;
    last_error_next   = last_error;
    flashes_done_next = flashes_done;
    step_timer_next   = step_timer;
    last_phase_next   = last_phase;
    series_step       = 1'b0;
    fast_phase        = 1'b0;
    t                 = 4'd0;
    if (item.tick) begin
      if (item.error_code != 7'd0) begin
        // Error series: restart on a new code, else count down the timer
        if (last_error != item.error_code) begin
          led_level_next    = 1'b0;
          last_error_next   = item.error_code;
          flashes_done_next = 7'd0;
          step_timer_next   = 4'd0;
          series_step       = 1'b1;
        end else begin
          step_timer_next = step_timer - 4'd1;
          series_step     = (step_timer_next == 4'd0);
        end
        if (series_step) begin
          if (item.error_code != flashes_done_next) begin
            if (led_level_next) begin
              step_timer_next   = FLASH_OFF_TICKS;
              led_level_next    = 1'b0;
              flashes_done_next = flashes_done_next + 7'd1;
            end else begin
              led_level_next  = 1'b1;
              step_timer_next = FLASH_ON_TICKS;
            end
          end else begin
            led_level_next    = 1'b0;
            step_timer_next   = SERIES_PAUSE;
            flashes_done_next = 7'd0;
          end
        end
      end else begin
        // Leave error mode
        if (last_error != 7'd0) begin
          last_error_next   = 7'd0;
          step_timer_next   = 4'd1;
          flashes_done_next = 7'd0;
        end
        // Restart the pattern on a phase change
        if (item.phase != last_phase) begin
          step_timer_next = 4'd0;
          last_phase_next = item.phase;
        end
        if (item.phase == RUN_PHASE) begin
          led_level_next = ~item.cal_request;
        end else begin
          fast_phase = (item.phase == FAST_PHASE_LOW) || (item.phase == FAST_PHASE_HIGH);
          t          = step_timer_next;
          if (fast_phase) begin
            if (t >= FAST_PERIOD) t = 4'd0;
            led_level_next = (t < FAST_ON);
          end else begin
            if (t >= SLOW_PERIOD) t = 4'd0;
            led_level_next = (t < SLOW_ON);
          end
          step_timer_next = t + 4'd1;
        end
      end
    end
  end

  assign led_next = led_level_next;

  // Advance the state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      led_level    <= 1'b0;
      last_error   <= 7'd0;
      flashes_done <= 7'd0;
      step_timer   <= 4'd0;
      last_phase   <= 8'd0;
    end else if (en) begin
      led_level    <= led_level_next;
      last_error   <= last_error_next;
      flashes_done <= flashes_done_next;
      step_timer   <= step_timer_next;
      last_phase   <= last_phase_next;
    end
  end

  // A non-tick item leaves the LED state alone
  a_no_tick_hold: assert property (@(posedge clk) disable iff (rst)
    en && !item.tick |=> $stable(led_level) && $stable(step_timer) && $stable(last_error))
    else $error("state changed on a non-tick item");

  // A new error code starts the series with a lit flash
  a_new_code_flash: assert property (@(posedge clk) disable iff (rst)
    en && item.tick && item.error_code != 7'd0 && item.error_code != last_error
    |=> led_level && step_timer == FLASH_ON_TICKS && flashes_done == 7'd0)
    else $error("new error code did not start a flash");

  // The flash count never runs past the code being shown
  a_flash_bound: assert property (@(posedge clk) disable iff (rst)
    flashes_done <= last_error)
    else $error("flash count exceeds error code");

endmodule

/* src/status_led_blink_code.sv */
// Top level of the status LED blink code generator: input register, pattern
// logic and output register. Depends on slbc_pkg and slbc_pattern.
// Path: an accepted item is held in the input register, passes through the pattern
//   logic into the output register and raises m_tvalid there until its transfer.
// Throughput: one item per cycle while m_tready does not stall the output register.
// Reset (rst, synchronous): pattern LED level off, all counters and codes cleared, no items held.
module status_led_blink_code (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [0] tick, [7:1] error_code, [15:8] phase, [16] cal_request, [23:17] zero
  input  logic [slbc_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] led_on, [7:1] zero
  output logic [slbc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import slbc_pkg::*;

  logic  in_full;
  item_t in_item;
  logic  advance;
  logic  led_next;
  logic  led_on;

  // Move the held item on when the output register is free or being drained
  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.tick        <= s_tdata[0];
      in_item.error_code  <= s_tdata[7:1];
      in_item.phase       <= s_tdata[15:8];
      in_item.cal_request <= s_tdata[16];
    end
  end

  slbc_pattern u_pattern (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .item     (in_item),
    .led_next (led_next)
  );

  // Output register: hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_on <= led_next;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, led_on};

  // A held item that cannot move blocks new transfers
  a_block_when_full: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |-> !s_tready)
    else $error("input accepted while input register is blocked");

  // A stalled item stays in the input register
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_item))
    else $error("stalled item lost");

  // Every processed item shows up as a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed item produced no result");

endmodule
